@@ hdl/rdmc_pkg.sv @@
package rdmc_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] T_WALL  = 2'd0;
  localparam logic [1:0] T_PASS  = 2'd1;
  localparam logic [1:0] T_START = 2'd2;
  localparam logic [1:0] T_END   = 2'd3;

  localparam logic [3:0] ALL_DIRS = 4'hF;
  localparam int         DIM_MIN  = 3;
  localparam int         DIM_RST  = 15;

  localparam logic [2:0] A_CLR   = 3'd0;
  localparam logic [2:0] A_CUR   = 3'd1;
  localparam logic [2:0] A_TGT   = 3'd2;
  localparam logic [2:0] A_WALL  = 3'd3;
  localparam logic [2:0] A_START = 3'd4;
  localparam logic [2:0] A_END   = 3'd5;
  localparam logic [2:0] A_RD    = 3'd6;

  localparam logic [2:0] W_CLR   = 3'd0;
  localparam logic [2:0] W_MASK  = 3'd1;
  localparam logic [2:0] W_TGT   = 3'd2;
  localparam logic [2:0] W_WALL  = 3'd3;
  localparam logic [2:0] W_START = 3'd4;
  localparam logic [2:0] W_END   = 3'd5;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Store word: kind, untried mask, visited, parent direction.
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] untried;
    logic       visited;
    logic [1:0] parent;
  } rdmc_word_t;

  typedef struct packed {
    logic       latch_in;
    logic       clr_start;
    logic       clr_step;
    logic [2:0] addr_sel;
    logic       we;
    logic [2:0] wd_sel;
    logic       move_tgt;
    logic       move_back;
    logic       set_fin;
    logic       set_type;
    logic       out_load;
  } rdmc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bit_untried;
    logic tgt_ok;
    logic tgt_free;
    logic mask_zero;
    logic at_home;
    logic back_home;
    logic can_draw;
    logic out_free;
  } rdmc_stat_t;

endpackage

@@ hdl/rdmc_ctrl.sv @@
module rdmc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_kind,
  output logic                in_stall,
  input  rdmc_pkg::rdmc_stat_t stat,
  output rdmc_pkg::rdmc_cmd_t  cmd
);
  import rdmc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RDC  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_RDT  = 4'd4;
  localparam logic [3:0] S_TCHK = 4'd5;
  localparam logic [3:0] S_WALL = 4'd6;
  localparam logic [3:0] S_BRD  = 4'd7;
  localparam logic [3:0] S_BCHK = 4'd8;
  localparam logic [3:0] S_FS   = 4'd9;
  localparam logic [3:0] S_FE   = 4'd10;
  localparam logic [3:0] S_RD   = 4'd11;
  localparam logic [3:0] S_RDW  = 4'd12;
  localparam logic [3:0] S_RES  = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.addr_sel = A_CUR;
    cmd.wd_sel   = W_CLR;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_kind)
            KIND_START: begin
              cmd.clr_start = 1'b1;
              state_nxt = S_CLR;
            end
            KIND_DRAW: state_nxt = stat.can_draw ? S_RDC : S_RES;
            KIND_READ: state_nxt = S_RD;
            default:   state_nxt = S_RES;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.addr_sel = A_CLR;
        cmd.we       = 1'b1;
        cmd.wd_sel   = W_CLR;
        if (stat.clr_last) state_nxt = S_RES;
      end
      S_RDC: state_nxt = S_CHK;
      S_CHK: begin
        if (stat.bit_untried) begin
          cmd.we     = 1'b1;
          cmd.wd_sel = W_MASK;
          state_nxt  = stat.tgt_ok ? S_RDT : S_BRD;
        end else begin
          state_nxt = S_BRD;
        end
      end
      S_RDT: begin
        cmd.addr_sel = A_TGT;
        state_nxt    = S_TCHK;
      end
      S_TCHK: begin
        cmd.addr_sel = A_TGT;
        if (stat.tgt_free) begin
          cmd.we     = 1'b1;
          cmd.wd_sel = W_TGT;
          state_nxt  = S_WALL;
        end else begin
          state_nxt = S_BRD;
        end
      end
      S_WALL: begin
        cmd.addr_sel = A_WALL;
        cmd.we       = 1'b1;
        cmd.wd_sel   = W_WALL;
        cmd.move_tgt = 1'b1;
        state_nxt    = S_RES;
      end
      S_BRD: state_nxt = S_BCHK;
      S_BCHK: begin
        if (!stat.mask_zero) begin
          state_nxt = S_RES;
        end else if (stat.at_home) begin
          state_nxt = S_FS;
        end else begin
          cmd.move_back = 1'b1;
          state_nxt = stat.back_home ? S_FS : S_BRD;
        end
      end
      S_FS: begin
        cmd.addr_sel = A_START;
        cmd.we       = 1'b1;
        cmd.wd_sel   = W_START;
        cmd.set_fin  = 1'b1;
        state_nxt    = S_FE;
      end
      S_FE: begin
        cmd.addr_sel = A_END;
        cmd.we       = 1'b1;
        cmd.wd_sel   = W_END;
        state_nxt    = S_RES;
      end
      S_RD: begin
        cmd.addr_sel = A_RD;
        state_nxt    = S_RDW;
      end
      S_RDW: begin
        cmd.set_type = 1'b1;
        state_nxt    = S_RES;
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/rdmc_dp.sv @@
module rdmc_dp #(
  parameter int MAX_DIM = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_wdata,
  input  logic [1:0]           in_rand_dir,
  input  logic [5:0]           in_cell_row,
  input  logic [5:0]           in_cell_col,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_done_res,
  output logic [5:0]           out_cursor_row,
  output logic [5:0]           out_cursor_col,
  output logic [1:0]           out_cell_type,
  input  rdmc_pkg::rdmc_cmd_t  cmd,
  output rdmc_pkg::rdmc_stat_t stat
);
  import rdmc_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);

  rdmc_word_t mem [CELLS];
  rdmc_word_t mem_q_r;
  rdmc_word_t wdata;
  logic [AW-1:0] addr;

  logic [6:0]    cfg_w_r, cfg_h_r;
  logic [DW-1:0] act_w_r, act_h_r;
  logic [CW-1:0] cur_r_r, cur_c_r, cur_r_nxt, cur_c_nxt;
  logic [CW-1:0] clr_r_r, clr_c_r;
  logic [1:0]    dir_r;
  logic [5:0]    rd_row_r, rd_col_r;
  logic [1:0]    type_r;
  logic          fin_r, armed_r, out_valid_r;
  logic          out_done_r;
  logic [5:0]    out_row_r, out_col_r;
  logic [1:0]    out_type_r;

  logic [CW-1:0] tgt_r, tgt_c, wall_r, wall_c, back_r, back_c;
  logic          clr_pass, rd_in;
  logic          tgt_ok;

  function automatic logic [AW-1:0] idx(input int r, input int c);
    idx = AW'(r * MAX_DIM + c);
  endfunction

  function automatic logic [DW-1:0] clamp(input logic [6:0] v);
    int t;
    t = int'(v);
    if (t < DIM_MIN) t = DIM_MIN;
    if (t > MAX_DIM) t = MAX_DIM;
    clamp = DW'(t);
  endfunction

  always_comb begin
    tgt_r = cur_r_r;
    tgt_c = cur_c_r;
    wall_r = cur_r_r;
    wall_c = cur_c_r;
    tgt_ok = 1'b0;
    case (dir_r)
      2'd0: begin
        tgt_ok = int'(cur_r_r) >= 2;
        tgt_r  = CW'(int'(cur_r_r) - 2);
        wall_r = CW'(int'(cur_r_r) - 1);
      end
      2'd1: begin
        tgt_ok = int'(cur_r_r) + 2 < int'(act_h_r);
        tgt_r  = CW'(int'(cur_r_r) + 2);
        wall_r = CW'(int'(cur_r_r) + 1);
      end
      2'd2: begin
        tgt_ok = int'(cur_c_r) >= 2;
        tgt_c  = CW'(int'(cur_c_r) - 2);
        wall_c = CW'(int'(cur_c_r) - 1);
      end
      default: begin
        tgt_ok = int'(cur_c_r) + 2 < int'(act_w_r);
        tgt_c  = CW'(int'(cur_c_r) + 2);
        wall_c = CW'(int'(cur_c_r) + 1);
      end
    endcase
    back_r = cur_r_r;
    back_c = cur_c_r;
    case (mem_q_r.parent)
      2'd0:    back_r = CW'(int'(cur_r_r) + 2);
      2'd1:    back_r = CW'(int'(cur_r_r) - 2);
      2'd2:    back_c = CW'(int'(cur_c_r) + 2);
      default: back_c = CW'(int'(cur_c_r) - 2);
    endcase
  end

  assign clr_pass = (int'(clr_r_r) < int'(act_h_r)) && (int'(clr_c_r) < int'(act_w_r))
                    && clr_r_r[0] && clr_c_r[0];
  assign rd_in    = (int'(rd_row_r) < MAX_DIM) && (int'(rd_col_r) < MAX_DIM);

  assign stat.tgt_ok      = tgt_ok;
  assign stat.clr_last    = (int'(clr_r_r) == MAX_DIM - 1) && (int'(clr_c_r) == MAX_DIM - 1);
  assign stat.bit_untried = mem_q_r.untried[dir_r];
  assign stat.tgt_free    = (mem_q_r.kind == T_PASS) && !mem_q_r.visited;
  assign stat.mask_zero   = (mem_q_r.untried == 4'd0);
  assign stat.at_home     = (cur_r_r == CW'(1)) && (cur_c_r == CW'(1));
  assign stat.back_home   = (back_r == CW'(1)) && (back_c == CW'(1));
  assign stat.can_draw    = armed_r && !fin_r;
  assign stat.out_free    = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.addr_sel)
      A_CLR:   addr = idx(int'(clr_r_r), int'(clr_c_r));
      A_TGT:   addr = idx(int'(tgt_r), int'(tgt_c));
      A_WALL:  addr = idx(int'(wall_r), int'(wall_c));
      A_START: addr = idx(1, 1);
      A_END:   addr = idx(int'(act_h_r) - 2, int'(act_w_r) - 2);
      A_RD:    addr = idx(int'(rd_row_r), int'(rd_col_r));
      default: addr = idx(int'(cur_r_r), int'(cur_c_r));
    endcase
    wdata = mem_q_r;
    case (cmd.wd_sel)
      W_CLR: begin
        wdata.kind    = clr_pass ? T_PASS : T_WALL;
        wdata.untried = ALL_DIRS;
        wdata.visited = (clr_r_r == CW'(1)) && (clr_c_r == CW'(1));
        wdata.parent  = 2'd0;
      end
      W_MASK:  wdata.untried = mem_q_r.untried & ~(4'd1 << dir_r);
      W_TGT: begin
        wdata.visited = 1'b1;
        wdata.parent  = dir_r;
      end
      W_WALL:  wdata = '{kind: T_PASS, untried: ALL_DIRS, visited: 1'b0, parent: 2'd0};
      W_START: wdata = '{kind: T_START, untried: 4'd0, visited: 1'b1, parent: 2'd0};
      W_END:   wdata = '{kind: T_END, untried: 4'd0, visited: 1'b1, parent: 2'd0};
      default: wdata = mem_q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) mem[addr] <= wdata;
    mem_q_r <= mem[addr];
  end

  always_comb begin
    cur_r_nxt = cur_r_r;
    cur_c_nxt = cur_c_r;
    if (cmd.clr_start) begin
      cur_r_nxt = CW'(1);
      cur_c_nxt = CW'(1);
    end else if (cmd.move_tgt) begin
      cur_r_nxt = tgt_r;
      cur_c_nxt = tgt_c;
    end else if (cmd.move_back) begin
      cur_r_nxt = back_r;
      cur_c_nxt = back_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r     <= 7'(DIM_RST);
      cfg_h_r     <= 7'(DIM_RST);
      act_w_r     <= DW'(DIM_RST);
      act_h_r     <= DW'(DIM_RST);
      cur_r_r     <= CW'(1);
      cur_c_r     <= CW'(1);
      clr_r_r     <= '0;
      clr_c_r     <= '0;
      fin_r       <= 1'b0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_WIDTH)  cfg_w_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_HEIGHT) cfg_h_r <= cfg_wdata;
      cur_r_r <= cur_r_nxt;
      cur_c_r <= cur_c_nxt;
      if (cmd.clr_start) begin
        act_w_r <= clamp(cfg_w_r);
        act_h_r <= clamp(cfg_h_r);
        clr_r_r <= '0;
        clr_c_r <= '0;
        fin_r   <= 1'b0;
        armed_r <= 1'b1;
      end else if (cmd.clr_step) begin
        if (int'(clr_c_r) == MAX_DIM - 1) begin
          clr_c_r <= '0;
          clr_r_r <= CW'(int'(clr_r_r) + 1);
        end else begin
          clr_c_r <= CW'(int'(clr_c_r) + 1);
        end
      end
      if (cmd.set_fin) fin_r <= 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      dir_r    <= in_rand_dir;
      rd_row_r <= in_cell_row;
      rd_col_r <= in_cell_col;
      type_r   <= T_WALL;
    end else if (cmd.set_type) begin
      type_r <= (armed_r && rd_in) ? mem_q_r.kind : T_WALL;
    end
    if (cmd.out_load) begin
      out_done_r <= fin_r;
      out_row_r  <= 6'(int'(cur_r_r));
      out_col_r  <= 6'(int'(cur_c_r));
      out_type_r <= type_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_done_res   = out_done_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_type  = out_type_r;

endmodule

@@ hdl/random_dfs_maze_carver.sv @@
// Maze carver by randomised depth-first search over a MAX_DIM x MAX_DIM cell store, one
// single-port memory word per cell. One word is taken at a time and gives one result word.
// A start word sweeps the whole store, one cell a cycle. A read word reads its cell; a draw
// that is ignored or a word of an unused kind goes straight to its result. A draw clears
// the drawn bit of the current cell and, if the target cell is inside and free, marks it,
// opens the wall and moves there; else, while the cell has no untried bit, it backs up along
// parent directions and, on the start cell, writes the start and end cells. A result waits
// for a stalled last one, then waits in the output register while the next word is taken.
module random_dfs_maze_carver #(
  parameter int MAX_DIM = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [1:0] in_rand_dir,
  input  logic [5:0] in_cell_row,
  input  logic [5:0] in_cell_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_done_res,
  output logic [5:0] out_cursor_row,
  output logic [5:0] out_cursor_col,
  output logic [1:0] out_cell_type
);
  import rdmc_pkg::*;

  rdmc_cmd_t  cmd;
  rdmc_stat_t stat;

  rdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rdmc_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_rand_dir    (in_rand_dir),
    .in_cell_row    (in_cell_row),
    .in_cell_col    (in_cell_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_done_res   (out_done_res),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_type  (out_cell_type),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

@@ hdl/rdmc_checker.sv @@
module rdmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_cursor_row
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block took a word without going busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_row))
    else $error("stalled result word changed");

endmodule

bind random_dfs_maze_carver rdmc_checker u_rdmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cursor_row (out_cursor_row)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import rdmc_pkg::*;

  localparam int DIM = 64;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 12;
  localparam int RANDOM_ITEMS = 1783;
  localparam logic [1:0] KIND_NOP = 2'd3;
  localparam logic [1:0] DIR_UP = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_LEFT = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic       done;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] ctype;
  } carve_res_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [6:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_kind;
  logic [1:0] in_rand_dir;
  logic [5:0] in_cell_row;
  logic [5:0] in_cell_col;
  logic       out_valid;
  logic       out_stall;
  logic       out_done_res;
  logic [5:0] out_cursor_row;
  logic [5:0] out_cursor_col;
  logic [1:0] out_cell_type;

  carve_res_t expected_q[$];
  int         mismatches;
  int         idle_cycles;
  bit         burst;
  bit         long_hold;

  logic [1:0] sq_kind[DIM*DIM];
  logic [3:0] sq_untried[DIM*DIM];
  bit         sq_seen[DIM*DIM];
  logic [1:0] sq_parent[DIM*DIM];
  int         cur_r, cur_c;
  bit         run_done, run_armed;
  int         reg_w, reg_h, act_w, act_h;

  random_dfs_maze_carver uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_dim(int v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM) return DIM;
    return v;
  endfunction

  function automatic void maze_restart();
    act_w = clamp_dim(reg_w);
    act_h = clamp_dim(reg_h);
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        sq_kind[r*DIM+c] = (r < act_h && c < act_w && r[0] && c[0]) ? T_PASS : T_WALL;
        sq_untried[r*DIM+c] = ALL_DIRS;
        sq_seen[r*DIM+c] = 1'b0;
      end
    end
    cur_r = 1;
    cur_c = 1;
    sq_seen[DIM+1] = 1'b1;
    run_done = 1'b0;
    run_armed = 1'b1;
  endfunction

  function automatic void maze_finish();
    run_done = 1'b1;
    sq_kind[DIM+1] = T_START;
    sq_kind[(act_h-2)*DIM+act_w-2] = T_END;
  endfunction

  function automatic void maze_draw(logic [1:0] d);
    int  here, tr, tc, t;
    bit  ok;
    here = cur_r*DIM + cur_c;
    tr = cur_r;
    tc = cur_c;
    ok = 1'b0;
    if (sq_untried[here][d]) begin
      sq_untried[here][d] = 1'b0;
      case (d)
        DIR_UP: if (cur_r >= 2) begin tr = cur_r - 2; ok = 1'b1; end
        DIR_DOWN: if (cur_r + 2 < act_h) begin tr = cur_r + 2; ok = 1'b1; end
        DIR_LEFT: if (cur_c >= 2) begin tc = cur_c - 2; ok = 1'b1; end
        default: if (cur_c + 2 < act_w) begin tc = cur_c + 2; ok = 1'b1; end
      endcase
      if (ok) begin
        t = tr*DIM + tc;
        if (sq_kind[t] == T_PASS && !sq_seen[t]) begin
          sq_seen[t] = 1'b1;
          sq_parent[t] = d;
          sq_kind[((tr+cur_r)/2)*DIM + (tc+cur_c)/2] = T_PASS;
          cur_r = tr;
          cur_c = tc;
          return;
        end
      end
    end
    for (int s = 0; s < DIM*DIM && sq_untried[cur_r*DIM+cur_c] == 4'd0; s++) begin
      if (cur_r == 1 && cur_c == 1) begin
        maze_finish();
        return;
      end
      case (sq_parent[cur_r*DIM+cur_c])
        DIR_UP: cur_r += 2;
        DIR_DOWN: cur_r -= 2;
        DIR_LEFT: cur_c += 2;
        default: cur_c -= 2;
      endcase
      if (cur_r == 1 && cur_c == 1) begin
        maze_finish();
        return;
      end
    end
  endfunction

  function automatic carve_res_t predict_carve(logic [1:0] k, logic [1:0] d,
                                               logic [5:0] r, logic [5:0] c);
    carve_res_t res;
    res.ctype = T_WALL;
    case (k)
      KIND_START: maze_restart();
      KIND_DRAW: if (run_armed && !run_done) maze_draw(d);
      KIND_READ: res.ctype = sq_kind[r*DIM+c];
      default: ;
    endcase
    res.done = run_done;
    res.row = cur_r[5:0];
    res.col = cur_c[5:0];
    return res;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_word(input logic [1:0] k, input logic [1:0] d,
                           input logic [5:0] r, input logic [5:0] c);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind <= k;
    in_rand_dir <= d;
    in_cell_row <= r;
    in_cell_col <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_carve(k, d, r, c));
  endtask

  task automatic send_draw(input logic [1:0] d);
    send_word(KIND_DRAW, d, 6'($urandom), 6'($urandom));
  endtask

  task automatic send_read(input int r, input int c);
    send_word(KIND_READ, 2'($urandom), r[5:0], c[5:0]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_grid(input int w, input int h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_wdata <= w[6:0];
    @(posedge clk);
    reg_w = w;
    cfg_index <= CFG_HEIGHT;
    cfg_wdata <= h[6:0];
    @(posedge clk);
    reg_h = h;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int hold;
    carve_res_t want;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold) begin
        hold = 400;
        long_hold = 1'b0;
      end else begin
        hold = burst ? 0 : $urandom_range(0, 18);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_q.size() == 0) begin
        report("unexpected word", out_cursor_row, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_done_res !== want.done) report("done_res", out_done_res, want.done);
        if (out_cursor_row !== want.row) report("cursor_row", out_cursor_row, want.row);
        if (out_cursor_col !== want.col) report("cursor_col", out_cursor_col, want.col);
        if (out_cell_type !== want.ctype) report("cell_type", out_cell_type, want.ctype);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("random_dfs_maze_carver verification failed");
        $finish;
      end
    end
  end

  task automatic test_before_start();
    send_read(0, 0);
    send_read(1, 1);
    send_read(63, 63);
    for (int d = 0; d < 4; d++) send_draw(d[1:0]);
    send_word(KIND_NOP, DIR_RIGHT, 6'd63, 6'd63);
  endtask

  task automatic test_default_grid();
    send_word(KIND_START, DIR_UP, 6'd0, 6'd0);
    send_draw(DIR_UP);
    send_draw(DIR_UP);
    send_draw(DIR_DOWN);
    send_draw(DIR_RIGHT);
    send_draw(DIR_LEFT);
    send_read(1, 2);
    send_read(2, 1);
    send_read(14, 14);
    send_read(20, 20);
  endtask

  task automatic test_smallest_grid();
    set_grid(3, 3);
    send_word(KIND_START, DIR_UP, 6'd0, 6'd0);
    for (int d = 0; d < 4; d++) send_draw(d[1:0]);
    send_read(1, 1);
    send_draw(DIR_DOWN);
    send_read(5, 5);
    send_read(63, 0);
  endtask

  task automatic test_backpressure();
    drain();
    long_hold = 1'b1;
    burst = 1'b1;
    for (int i = 0; i < 40; i++) send_read($urandom_range(0, 63), $urandom_range(0, 63));
    burst = 1'b0;
    drain();
  endtask

  function automatic int pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 2 * $urandom_range(1, 7) + 1;
    if (sel == 7) return $urandom_range(3, 20);
    if (sel == 8) begin
      case ($urandom_range(0, 5))
        0: return 0;
        1: return 1;
        2: return 2;
        3: return 64;
        4: return 65;
        default: return 127;
      endcase
    end
    return 2 * $urandom_range(15, 31) + 1;
  endfunction

  task automatic test_random_carving();
    int sent, after, sel;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_grid(pick_dim(), pick_dim());
      burst = ($urandom_range(0, 3) == 0);
      send_word(KIND_START, 2'($urandom), 6'($urandom), 6'($urandom));
      sent++;
      after = 0;
      for (int i = 0; i < 400 && after < 10 && sent < RANDOM_ITEMS; i++) begin
        sel = $urandom_range(0, 39);
        if (sel < 28) send_draw(2'($urandom));
        else if (sel < 36) send_read($urandom_range(0, act_h - 1), $urandom_range(0, act_w - 1));
        else if (sel < 38) send_read($urandom_range(0, 63), $urandom_range(0, 63));
        else if (sel == 38) send_word(KIND_NOP, 2'($urandom), 6'($urandom), 6'($urandom));
        else send_word(KIND_START, 2'($urandom), 6'($urandom), 6'($urandom));
        sent++;
        if (run_done) after++;
      end
      burst = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_wdata = 7'd0;
    in_valid = 1'b0;
    in_kind = KIND_READ;
    in_rand_dir = DIR_UP;
    in_cell_row = 6'd0;
    in_cell_col = 6'd0;
    out_stall = 1'b0;
    mismatches = 0;
    burst = 1'b0;
    long_hold = 1'b0;
    for (int i = 0; i < DIM*DIM; i++) begin
      sq_kind[i] = T_WALL;
      sq_untried[i] = ALL_DIRS;
      sq_seen[i] = 1'b0;
      sq_parent[i] = DIR_UP;
    end
    cur_r = 1;
    cur_c = 1;
    run_done = 1'b0;
    run_armed = 1'b0;
    reg_w = DIM_RST;
    reg_h = DIM_RST;
    act_w = DIM_RST;
    act_h = DIM_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_start();
    test_default_grid();
    test_smallest_grid();
    test_backpressure();
    test_random_carving();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("random_dfs_maze_carver verification clean");
    end else begin
      $display("random_dfs_maze_carver verification failed");
    end
    $finish;
  end

endmodule
